[design/tmts_pkg.sv]
// Shared constants, beat types and character classes of the multi-term text scorer.
package tmts_pkg;

   localparam int MaxTerms    = 8;
   localparam int MaxTermLen  = 32;
   localparam int ScoreBits   = 24;
   localparam int TermIdxW    = $clog2(MaxTerms);
   localparam int TermCountW  = $clog2(MaxTerms + 1);
   localparam int RowW        = $clog2(MaxTermLen);
   localparam int LenW        = $clog2(MaxTermLen + 1);
   localparam int WordLenW    = 6;
   localparam int BonusW      = 6;
   localparam int AddW        = 7;

   localparam logic [WordLenW-1:0]  WordLenMax  = 6'd63;
   localparam logic [3:0]           NoTerm      = 4'd15;
   localparam logic [ScoreBits-1:0] StartScore  = ScoreBits'(10);
   localparam logic [AddW-1:0]      ExactBonus  = 7'd10;
   localparam logic [BonusW-1:0]    AdjBonus    = 6'd50;
   localparam logic [ScoreBits-1:0] ScoreMax    = {ScoreBits{1'b1}};
   localparam logic [7:0]           Underscore  = 8'h5F;

   localparam logic ReqPattern  = 1'b0;
   localparam logic ReqDocument = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic [ScoreBits-1:0] score;
      logic                 all_terms_seen;
      logic                 score_saturated;
      logic                 pattern_truncated;
   } rsp_beat_type;

   typedef struct packed {
      logic                en;
      logic [RowW-1:0]     row;
      logic [TermIdxW-1:0] lane;
      logic [7:0]          data;
   } mem_wr_type;

   typedef struct packed {
      logic            en;
      logic [RowW-1:0] row;
      logic [7:0]      key;
   } mem_rd_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_boundary(input logic [7:0] c);
      return (c < 8'h30) || (c >= 8'h3A && c <= 8'h40) || (c >= 8'h5B && c <= 8'h5E) ||
             (c == 8'h60) || (c >= 8'h7B && c <= 8'h7F);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

endpackage

[design/tmts_term_store.sv]
// Term character memory: one row per character position, one byte lane per term.
module tmts_term_store
   import tmts_pkg::*;
(
   input  logic                clock,
   input  mem_wr_type          wr,
   input  mem_rd_type          rd,
   output logic [MaxTerms-1:0] lane_eq
);

   logic [MaxTerms-1:0][7:0] term_mem_ff [MaxTermLen];
   logic [MaxTerms-1:0][7:0] rd_data_ff;
   logic [7:0]               key_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         term_mem_ff[wr.row][wr.lane] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= term_mem_ff[rd.row];
         key_ff     <= rd.key;
      end
   end

   always_comb begin
      for (int j = 0; j < MaxTerms; j++) begin
         lane_eq[j] = (rd_data_ff[j] == key_ff);
      end
   end

endmodule

[design/multi_term_text_scorer_core.sv]
// Top level of the multi-term text scorer: term loader, word matcher and scoring.
//
// Usage: bytes enter on req_valid/req_ready with req_data (req_type, data_byte,
// last_byte). Pattern beats (req_type 0) build up to 8 lower-cased terms; the
// first pattern beat after a pattern's last beat starts a new pattern. Document
// beats (req_type 1) are split into words and matched as prefixes against all
// terms at once. Pattern beats never give a result; the last beat of a document
// gives one result beat on rsp_valid/rsp_ready with rsp_data.
// Throughput: one beat per cycle unless stalled. A non-boundary document beat
// reads one row of the term memory (all terms at that character position) when
// accepted, and is compared and scored in the scoring stage; the result is
// registered, so rsp_valid rises once the last document beat leaves that stage.
// Stall: while a result waits in the output register, beats keep flowing until
// the next document's last beat reaches the scoring stage; that stage then
// holds, and req_ready drops until rsp_ready takes the waiting result.
// Reset: synchronous, active high; terms are cleared to none and the document
// state to a score of 10. The term memory needs no clearing pass.
module multi_term_text_scorer_core
   import tmts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_data
);

   // pattern state
   logic [LenW-1:0]       term_len_ff [MaxTerms];
   logic [LenW-1:0]       term_len_in [MaxTerms];
   logic [TermCountW-1:0] term_count_ff, term_count_in;
   logic                  term_open_ff, term_open_in;
   logic                  pattern_fresh_ff, pattern_fresh_in;
   logic                  overflow_ff, overflow_in;

   // word tracking at the read stage
   logic                in_word_ff, in_word_in;
   logic [WordLenW-1:0] word_len_ff, word_len_in;

   // scoring stage
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_char_ff, s1_start_ff, s1_finish_ff, s1_last_ff;
   logic [WordLenW-1:0] s1_pos_ff;
   logic                s1_go;

   // document state
   logic [MaxTerms-1:0]  alive_ff, alive_in, completed_ff, completed_in;
   logic [MaxTerms-1:0]  seen_ff, seen_in;
   logic [3:0]           prev_term_ff, prev_term_in;
   logic [BonusW-1:0]    bonus_ff, bonus_in;
   logic [ScoreBits-1:0] score_ff, score_in;
   logic                 clamped_ff, clamped_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_data_ff, rsp_data_in;

   logic                  req_acc, pat_acc, doc_acc, byte_bnd;
   logic [7:0]            lc;
   logic [TermCountW-1:0] cnt_eff;
   logic                  open_eff;
   logic [TermIdxW-1:0]   open_idx;
   logic [LenW-1:0]       open_len;
   mem_wr_type            mem_wr;
   mem_rd_type            mem_rd;
   logic [MaxTerms-1:0]   lane_eq;
   logic [MaxTerms-1:0]   term_mask;

   logic [MaxTerms-1:0]  alive_upd, comp_upd;
   logic                 win_found;
   logic [TermIdxW-1:0]  win_idx;
   logic                 win_adj;
   logic [AddW-1:0]      add_val;
   logic [ScoreBits:0]   score_sum;
   logic [ScoreBits-1:0] score_new;
   logic                 clamped_new;
   logic [MaxTerms-1:0]  seen_new;
   logic [3:0]           prev_new;
   logic [BonusW-1:0]    bonus_new;
   logic                 all_seen;

   tmts_term_store u_store (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .lane_eq (lane_eq)
   );

   assign s1_go     = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_acc   = req_valid && req_ready;
   assign pat_acc   = req_acc && (req_data.req_type == ReqPattern);
   assign doc_acc   = req_acc && (req_data.req_type == ReqDocument);
   assign byte_bnd  = is_boundary(req_data.data_byte);
   assign lc        = to_lower(req_data.data_byte);

   // pattern loader
   always_comb begin
      cnt_eff          = pattern_fresh_ff ? '0 : term_count_ff;
      open_eff         = pattern_fresh_ff ? 1'b0 : term_open_ff;
      open_idx         = TermIdxW'(cnt_eff - 1'b1);
      open_len         = pattern_fresh_ff ? '0 : term_len_ff[open_idx];
      term_count_in    = term_count_ff;
      term_open_in     = term_open_ff;
      pattern_fresh_in = pattern_fresh_ff;
      overflow_in      = overflow_ff;
      term_len_in      = term_len_ff;
      mem_wr           = '{en: 1'b0, row: '0, lane: '0, data: lc};
      if (pat_acc) begin
         if (pattern_fresh_ff) begin
            for (int j = 0; j < MaxTerms; j++) begin
               term_len_in[j] = '0;
            end
            overflow_in = 1'b0;
         end
         term_count_in    = cnt_eff;
         term_open_in     = open_eff;
         pattern_fresh_in = 1'b0;
         if (open_eff && cnt_eff != '0) begin
            if (is_alnum(req_data.data_byte) || req_data.data_byte == Underscore) begin
               if (open_len < LenW'(MaxTermLen)) begin
                  mem_wr.en             = 1'b1;
                  mem_wr.row            = open_len[RowW-1:0];
                  mem_wr.lane           = open_idx;
                  term_len_in[open_idx] = open_len + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
            end else begin
               term_open_in = 1'b0;
            end
         end else if (is_alnum(req_data.data_byte) &&
                      cnt_eff < TermCountW'(MaxTerms)) begin
            mem_wr.en                            = 1'b1;
            mem_wr.row                           = '0;
            mem_wr.lane                          = cnt_eff[TermIdxW-1:0];
            term_len_in[cnt_eff[TermIdxW-1:0]]   = LenW'(1);
            term_count_in                        = cnt_eff + 1'b1;
            term_open_in                         = 1'b1;
         end
         if (req_data.last_byte) begin
            term_open_in     = 1'b0;
            pattern_fresh_in = 1'b1;
         end
      end
   end

   // word tracking and memory read
   always_comb begin
      in_word_in  = in_word_ff;
      word_len_in = word_len_ff;
      if (doc_acc) begin
         if (byte_bnd || req_data.last_byte) begin
            in_word_in  = 1'b0;
            word_len_in = '0;
         end else begin
            in_word_in  = 1'b1;
            word_len_in = (word_len_ff == WordLenMax) ? word_len_ff : word_len_ff + 1'b1;
         end
      end
      mem_rd = '{en: doc_acc && !byte_bnd, row: word_len_ff[RowW-1:0], key: lc};
      s1_valid_in = doc_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   end

   always_comb begin
      for (int j = 0; j < MaxTerms; j++) begin
         term_mask[j] = (TermCountW'(j) < term_count_ff);
      end
   end

   // match and score
   always_comb begin
      alive_upd = s1_start_ff ? term_mask : alive_ff;
      comp_upd  = s1_start_ff ? '0 : completed_ff;
      if (!s1_char_ff) begin
         alive_upd = alive_ff;
         comp_upd  = completed_ff;
      end else begin
         for (int j = 0; j < MaxTerms; j++) begin
            if (alive_upd[j]) begin
               if (LenW'(s1_pos_ff) >= term_len_ff[j] || s1_pos_ff >= WordLenW'(MaxTermLen) ||
                   !lane_eq[j]) begin
                  alive_upd[j] = 1'b0;
               end else if (LenW'(s1_pos_ff) + 1'b1 == term_len_ff[j]) begin
                  comp_upd[j] = 1'b1;
               end
            end
         end
      end

      win_found = 1'b0;
      win_idx   = '0;
      for (int j = MaxTerms - 1; j >= 0; j--) begin
         if (comp_upd[j]) begin
            win_found = 1'b1;
            win_idx   = TermIdxW'(j);
         end
      end
      win_adj = ({1'b0, prev_term_ff} + 5'd1) == 5'(win_idx);
      add_val = AddW'(1);
      if (!seen_ff[win_idx] && alive_upd[win_idx]) begin
         add_val = add_val + ExactBonus;
      end
      if (win_adj) begin
         add_val = add_val + AddW'(bonus_ff);
      end
      score_sum   = {1'b0, score_ff} + (ScoreBits + 1)'(add_val);
      score_new   = score_ff;
      clamped_new = clamped_ff;
      seen_new    = seen_ff;
      prev_new    = prev_term_ff;
      bonus_new   = bonus_ff >> 1;
      if (s1_finish_ff && win_found) begin
         if (score_sum > {1'b0, ScoreMax}) begin
            score_new   = ScoreMax;
            clamped_new = 1'b1;
         end else begin
            score_new = score_sum[ScoreBits-1:0];
         end
         seen_new[win_idx] = 1'b1;
         prev_new          = 4'(win_idx);
         bonus_new         = AdjBonus >> 1;
      end else if (!s1_finish_ff) begin
         bonus_new = bonus_ff;
      end
      all_seen = (seen_new & term_mask) == term_mask;

      alive_in     = alive_ff;
      completed_in = completed_ff;
      seen_in      = seen_ff;
      prev_term_in = prev_term_ff;
      bonus_in     = bonus_ff;
      score_in     = score_ff;
      clamped_in   = clamped_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_data_ff;
      if (s1_go) begin
         alive_in     = s1_finish_ff ? '0 : alive_upd;
         completed_in = s1_finish_ff ? '0 : comp_upd;
         seen_in      = seen_new;
         prev_term_in = prev_new;
         bonus_in     = bonus_new;
         score_in     = score_new;
         clamped_in   = clamped_new;
         if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{score:             all_seen ? score_new : '0,
                             all_terms_seen:    all_seen,
                             score_saturated:   clamped_new,
                             pattern_truncated: overflow_ff};
            alive_in     = '0;
            completed_in = '0;
            seen_in      = '0;
            prev_term_in = NoTerm;
            bonus_in     = '0;
            score_in     = StartScore;
            clamped_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MaxTerms; j++) begin
            term_len_ff[j] <= '0;
         end
         term_count_ff    <= '0;
         term_open_ff     <= 1'b0;
         pattern_fresh_ff <= 1'b1;
         overflow_ff      <= 1'b0;
         in_word_ff       <= 1'b0;
         word_len_ff      <= '0;
         s1_valid_ff      <= 1'b0;
         alive_ff         <= '0;
         completed_ff     <= '0;
         seen_ff          <= '0;
         prev_term_ff     <= NoTerm;
         bonus_ff         <= '0;
         score_ff         <= StartScore;
         clamped_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         term_len_ff      <= term_len_in;
         term_count_ff    <= term_count_in;
         term_open_ff     <= term_open_in;
         pattern_fresh_ff <= pattern_fresh_in;
         overflow_ff      <= overflow_in;
         in_word_ff       <= in_word_in;
         word_len_ff      <= word_len_in;
         s1_valid_ff      <= s1_valid_in;
         alive_ff         <= alive_in;
         completed_ff     <= completed_in;
         seen_ff          <= seen_in;
         prev_term_ff     <= prev_term_in;
         bonus_ff         <= bonus_in;
         score_ff         <= score_in;
         clamped_ff       <= clamped_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (doc_acc) begin
         s1_char_ff   <= !byte_bnd;
         s1_start_ff  <= !in_word_ff;
         s1_finish_ff <= byte_bnd ? in_word_ff : req_data.last_byte;
         s1_last_ff   <= req_data.last_byte;
         s1_pos_ff    <= word_len_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result beat without a last document beat");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_pos_ff) && $stable(score_ff))
      else $error("scoring stage moved while stalled");

   a_word_len_idle: assert property (@(posedge clock) disable iff (reset)
      !in_word_ff |-> word_len_ff == '0)
      else $error("word length nonzero outside a word");

   a_term_count: assert property (@(posedge clock) disable iff (reset)
      term_count_ff <= TermCountW'(MaxTerms))
      else $error("term count above limit");

   a_bonus_range: assert property (@(posedge clock) disable iff (reset)
      bonus_ff <= (AdjBonus >> 1))
      else $error("adjacency bonus out of range");

endmodule
